/* design/kbd_pkg.sv */
// Shared types, codes and the set-1 key table for the keyboard scan decoder.
// No dependencies; the front end, back end, top level and bench import this package.
`default_nettype none

package kbd_pkg;

    localparam int CHAR_W = 7;

    // Scan codes of the tracked modifier keys
    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'd42;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'd170;
    localparam logic [7:0] SC_LCTRL_MAKE   = 8'd29;
    localparam logic [7:0] SC_LCTRL_BREAK  = 8'd157;

    // Characters that act as macro commands while ctrl is held, case-mapping codes and NUL
    localparam logic [CHAR_W-1:0] CH_LOWER_H = 7'd104;
    localparam logic [CHAR_W-1:0] CH_UPPER_H = 7'd72;
    localparam logic [CHAR_W-1:0] CH_LOWER_K = 7'd107;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'd97;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 7'd122;
    localparam logic [CHAR_W-1:0] CASE_DIFF  = 7'd32;
    localparam logic [CHAR_W-1:0] CH_NUL     = 7'd0;

    // Result kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_CHAR = 2'd1;
    localparam logic [1:0] KIND_PLAY = 2'd2;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_TYPED = 2'd1,
        MODE_UPPER = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_CHAR   = 2'd1,
        OP_RECORD = 2'd2,
        OP_PLAY   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_READ = 2'd1,
        BK_EMIT = 2'd2
    } t_back_state;

    typedef struct packed {
        logic  shift;
        logic  ctrl;
        t_mode mode;
    } t_status;

    function automatic logic [CHAR_W-1:0] to_upper(input logic [CHAR_W-1:0] ch);
        if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
            return ch - CASE_DIFF;
        end
        return ch;
    endfunction

    function automatic logic [CHAR_W-1:0] key_ascii(input logic [6:0] code);
        logic [CHAR_W-1:0] ch;
        unique case (code)
            7'd1:  ch = 7'd27;
            7'd2:  ch = 7'd49;
            7'd3:  ch = 7'd50;
            7'd4:  ch = 7'd51;
            7'd5:  ch = 7'd52;
            7'd6:  ch = 7'd53;
            7'd7:  ch = 7'd54;
            7'd8:  ch = 7'd55;
            7'd9:  ch = 7'd56;
            7'd10: ch = 7'd57;
            7'd11: ch = 7'd48;
            7'd12: ch = 7'd45;
            7'd13: ch = 7'd61;
            7'd14: ch = 7'd8;
            7'd15: ch = 7'd9;
            7'd16: ch = 7'd113;
            7'd17: ch = 7'd119;
            7'd18: ch = 7'd101;
            7'd19: ch = 7'd114;
            7'd20: ch = 7'd116;
            7'd21: ch = 7'd121;
            7'd22: ch = 7'd117;
            7'd23: ch = 7'd105;
            7'd24: ch = 7'd111;
            7'd25: ch = 7'd112;
            7'd26: ch = 7'd91;
            7'd27: ch = 7'd93;
            7'd28: ch = 7'd10;
            7'd30: ch = 7'd97;
            7'd31: ch = 7'd115;
            7'd32: ch = 7'd100;
            7'd33: ch = 7'd102;
            7'd34: ch = 7'd103;
            7'd35: ch = 7'd104;
            7'd36: ch = 7'd106;
            7'd37: ch = 7'd107;
            7'd38: ch = 7'd108;
            7'd39: ch = 7'd59;
            7'd40: ch = 7'd39;
            7'd41: ch = 7'd96;
            7'd43: ch = 7'd92;
            7'd44: ch = 7'd122;
            7'd45: ch = 7'd120;
            7'd46: ch = 7'd99;
            7'd47: ch = 7'd118;
            7'd48: ch = 7'd98;
            7'd49: ch = 7'd110;
            7'd50: ch = 7'd109;
            7'd51: ch = 7'd44;
            7'd52: ch = 7'd46;
            7'd53: ch = 7'd47;
            7'd55: ch = 7'd42;
            7'd57: ch = 7'd32;
            7'd71: ch = 7'd55;
            7'd72: ch = 7'd56;
            7'd73: ch = 7'd57;
            7'd74: ch = 7'd45;
            7'd75: ch = 7'd52;
            7'd76: ch = 7'd53;
            7'd77: ch = 7'd54;
            7'd78: ch = 7'd43;
            7'd79: ch = 7'd49;
            7'd80: ch = 7'd50;
            7'd81: ch = 7'd51;
            7'd82: ch = 7'd48;
            7'd83: ch = 7'd46;
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

/* design/kbd_front.sv */
// Front end: tracks modifier flags, record mode and fill count, and turns
// each accepted scan code into one command for the back end. Uses kbd_pkg.
`default_nettype none

module kbd_front #(
    parameter int RECORD_DEPTH = 10,
    parameter int IDX_W        = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [7:0]                 i_scan_code,
    input  wire logic                       i_q_full,
    output logic                            o_cmd_push,
    output kbd_pkg::t_op                    o_cmd_op,
    output kbd_pkg::t_status                o_cmd_status,
    output logic [kbd_pkg::CHAR_W-1:0]      o_cmd_ch,
    output logic [IDX_W-1:0]                o_cmd_idx
);
    import kbd_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RECORD_DEPTH - 1);

    logic             r_shift, n_shift;
    logic             r_ctrl, n_ctrl;
    t_mode            r_mode, n_mode;
    logic [IDX_W-1:0] r_count, n_count;
    logic [CHAR_W-1:0] ch_raw, ch;

    always_comb begin
        n_shift  = r_shift;
        n_ctrl   = r_ctrl;
        n_mode   = r_mode;
        n_count  = r_count;
        o_cmd_op = OP_NONE;
        o_cmd_idx = r_count;

        unique case (i_scan_code)
            SC_LSHIFT_MAKE:  n_shift = 1'b1;
            SC_LSHIFT_BREAK: n_shift = 1'b0;
            SC_LCTRL_MAKE:   n_ctrl  = 1'b1;
            SC_LCTRL_BREAK:  n_ctrl  = 1'b0;
            default: ;
        endcase

        ch_raw   = key_ascii(i_scan_code[6:0]);
        ch       = n_shift ? to_upper(ch_raw) : ch_raw;
        o_cmd_ch = ch;

        if (!i_scan_code[7]) begin
            if (!n_ctrl) begin
                unique case (r_mode)
                    MODE_IDLE: o_cmd_op = OP_CHAR;
                    MODE_TYPED, MODE_UPPER: begin
                        // drop the character and leave record mode when full
                        if (r_count == LAST_IDX) begin
                            n_mode = MODE_IDLE;
                        end else begin
                            o_cmd_op = OP_RECORD;
                            o_cmd_ch = (r_mode == MODE_UPPER) ? to_upper(ch) : ch;
                            n_count  = r_count + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end else begin
                if (ch == CH_LOWER_H) begin
                    n_mode  = MODE_TYPED;
                    n_count = '0;
                end else if (ch == CH_UPPER_H) begin
                    n_mode  = MODE_UPPER;
                    n_count = '0;
                end else if (ch == CH_LOWER_K) begin
                    o_cmd_op = OP_PLAY;
                    n_mode   = MODE_IDLE;
                    n_count  = '0;
                end
            end
        end

        o_cmd_status.shift = n_shift;
        o_cmd_status.ctrl  = n_ctrl;
        o_cmd_status.mode  = n_mode;
    end

    assign o_cmd_push = i_push && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= 1'b0;
            r_ctrl  <= 1'b0;
            r_mode  <= MODE_IDLE;
            r_count <= '0;
        end else if (o_cmd_push) begin
            r_shift <= n_shift;
            r_ctrl  <= n_ctrl;
            r_mode  <= n_mode;
            r_count <= n_count;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LAST_IDX)
        else $error("record count past last writable entry");

    a_release_no_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_push && i_scan_code[7] |-> o_cmd_op == OP_NONE)
        else $error("release code produced a character command");
`endif

endmodule

`default_nettype wire

/* design/kbd_cmd_fifo.sv */
// Short command queue between the front and back ends.
// Generic width; no package dependency.
`default_nettype none

module kbd_cmd_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_rdata,
    output logic                  o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* design/kbd_back.sv */
// Back end: executes queued commands, owns the record store and the result
// register, and steps through the store on playback. Uses kbd_pkg.
`default_nettype none

module kbd_back #(
    parameter int RECORD_DEPTH = 10,
    parameter int IDX_W        = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cmd_valid,
    input  wire kbd_pkg::t_op               i_cmd_op,
    input  wire kbd_pkg::t_status           i_cmd_status,
    input  wire logic [kbd_pkg::CHAR_W-1:0] i_cmd_ch,
    input  wire logic [IDX_W-1:0]           i_cmd_idx,
    output logic                            o_cmd_pop,
    input  wire logic                       i_pop,
    output logic                            o_empty,
    output logic [1:0]                      o_kind,
    output logic [kbd_pkg::CHAR_W-1:0]      o_char_code,
    output logic                            o_last,
    output kbd_pkg::t_status                o_status
);
    import kbd_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RECORD_DEPTH - 1);

    logic [CHAR_W-1:0] r_mem [RECORD_DEPTH];
    logic [CHAR_W-1:0] r_rd_data;
    logic              mem_we;

    t_back_state       r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [IDX_W-1:0]  r_play_cnt, n_play_cnt;
    t_status           r_play_status, n_play_status;

    logic              r_out_valid, n_out_valid;
    logic [1:0]        r_out_kind, n_out_kind;
    logic [CHAR_W-1:0] r_out_char, n_out_char;
    logic              r_out_last, n_out_last;
    t_status           r_out_status, n_out_status;
    logic              out_free;

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_play_cnt    = r_play_cnt;
        n_play_status = r_play_status;
        n_out_valid   = r_out_valid && !i_pop;
        n_out_kind    = r_out_kind;
        n_out_char    = r_out_char;
        n_out_last    = r_out_last;
        n_out_status  = r_out_status;
        o_cmd_pop     = 1'b0;
        mem_we        = 1'b0;
        out_free      = !r_out_valid || i_pop;

        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd_op)
                        OP_CHAR: begin
                            n_out_valid  = 1'b1;
                            n_out_kind   = KIND_CHAR;
                            n_out_char   = i_cmd_ch;
                            n_out_last   = 1'b1;
                            n_out_status = i_cmd_status;
                        end
                        OP_RECORD: begin
                            mem_we       = 1'b1;
                            n_out_valid  = 1'b1;
                            n_out_kind   = KIND_NONE;
                            n_out_char   = CH_NUL;
                            n_out_last   = 1'b1;
                            n_out_status = i_cmd_status;
                        end
                        OP_PLAY: begin
                            n_state       = BK_READ;
                            n_idx         = '0;
                            n_play_cnt    = i_cmd_idx;
                            n_play_status = i_cmd_status;
                        end
                        OP_NONE: begin
                            n_out_valid  = 1'b1;
                            n_out_kind   = KIND_NONE;
                            n_out_char   = CH_NUL;
                            n_out_last   = 1'b1;
                            n_out_status = i_cmd_status;
                        end
                    endcase
                end
            end
            BK_READ: n_state = BK_EMIT;
            BK_EMIT: begin
                if (out_free) begin
                    // entries at or past the fill count read as cleared
                    n_out_valid  = 1'b1;
                    n_out_kind   = KIND_PLAY;
                    n_out_char   = (r_idx < r_play_cnt) ? r_rd_data : CH_NUL;
                    n_out_last   = (r_idx == LAST_IDX);
                    n_out_status = r_play_status;
                    if (r_idx == LAST_IDX) begin
                        n_state = BK_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = BK_READ;
                    end
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_cmd_idx] <= i_cmd_ch;
        end
        r_rd_data <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_play_cnt    <= n_play_cnt;
        r_play_status <= n_play_status;
        r_out_kind    <= n_out_kind;
        r_out_char    <= n_out_char;
        r_out_last    <= n_out_last;
        r_out_status  <= n_out_status;
    end

    assign o_empty     = !r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_char_code = r_out_char;
    assign o_last      = r_out_last;
    assign o_status    = r_out_status;

`ifndef NO_ASSERTIONS
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != BK_IDLE |-> r_idx <= LAST_IDX)
        else $error("playback index past store depth");

    a_none_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind == KIND_NONE |-> r_out_char == CH_NUL)
        else $error("empty result carries a character");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind != KIND_PLAY |-> r_out_last)
        else $error("single result not marked last");

    a_no_pop_in_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != BK_IDLE |-> !o_cmd_pop && !mem_we)
        else $error("command taken during playback");
`endif

endmodule

`default_nettype wire

/* design/keyboard_scan_decoder_with_macro_top.sv */
// Top level of the set-1 keyboard scan decoder with record/playback macros.
// Depends on kbd_pkg, kbd_front, kbd_cmd_fifo and kbd_back.
//
// Usage:
//   Input channel: drive i_scan_code and raise push; a code transfers on a
//   clock edge where push is high and full is low. Result channel: while
//   empty is low the oldest result sits on o_kind, o_char_code, o_last and
//   the status ports; it transfers on an edge where pop is high.
//   Every code yields one result, except ctrl+k, which yields RECORD_DEPTH
//   playback results, the final one with o_last set.
//   A transferred code passes through the command queue and then the result
//   register, when the queue and the result register are free.
//   Throughput: the front end takes one code per cycle while the two-entry
//   command queue has room; the back end retires one command per cycle while
//   the result register is free and no playback runs; playback reads each
//   entry from the record store through a register, then emits it.
//   Reset (i_rst_n low at a clock edge) clears the flags, the mode, the fill
//   count, the queue and the result register; stored entries past the fill
//   count read as zero, so the store itself needs no clearing pass.
//   When the receiver stalls, the result register holds, the back end stops,
//   the queue fills and full rises until results drain.
`default_nettype none

module keyboard_scan_decoder_with_macro_top #(
    parameter int RECORD_DEPTH = 10
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic [7:0]                 i_scan_code,
    output logic                            empty,
    input  wire logic                       pop,
    output logic [1:0]                      o_kind,
    output logic [kbd_pkg::CHAR_W-1:0]      o_char_code,
    output logic                            o_last,
    output logic                            o_shift_held,
    output logic                            o_ctrl_held,
    output logic [1:0]                      o_record_mode
);
    import kbd_pkg::*;

    localparam int IDX_W      = $clog2(RECORD_DEPTH);
    localparam int OP_W       = $bits(t_op);
    localparam int ST_W       = $bits(t_status);
    localparam int CMD_W      = OP_W + ST_W + CHAR_W + IDX_W;
    localparam int QUEUE_DEPTH = 2;

    logic              front_push;
    t_op               front_op;
    t_status           front_status;
    logic [CHAR_W-1:0] front_ch;
    logic [IDX_W-1:0]  front_idx;

    logic [CMD_W-1:0]  q_wdata, q_rdata;
    logic              q_full, q_empty, q_pop;

    t_op               back_op;
    t_status           back_status;
    logic [CHAR_W-1:0] back_ch;
    logic [IDX_W-1:0]  back_idx;
    t_status           out_status;

    kbd_front #(
        .RECORD_DEPTH (RECORD_DEPTH),
        .IDX_W        (IDX_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_scan_code  (i_scan_code),
        .i_q_full     (q_full),
        .o_cmd_push   (front_push),
        .o_cmd_op     (front_op),
        .o_cmd_status (front_status),
        .o_cmd_ch     (front_ch),
        .o_cmd_idx    (front_idx)
    );

    assign q_wdata = {front_op, front_status, front_ch, front_idx};

    kbd_cmd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    assign back_op     = t_op'(q_rdata[CMD_W-1 -: OP_W]);
    assign back_status = t_status'(q_rdata[CMD_W-OP_W-1 -: ST_W]);
    assign back_ch     = q_rdata[IDX_W +: CHAR_W];
    assign back_idx    = q_rdata[IDX_W-1:0];

    kbd_back #(
        .RECORD_DEPTH (RECORD_DEPTH),
        .IDX_W        (IDX_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (!q_empty),
        .i_cmd_op     (back_op),
        .i_cmd_status (back_status),
        .i_cmd_ch     (back_ch),
        .i_cmd_idx    (back_idx),
        .o_cmd_pop    (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_kind       (o_kind),
        .o_char_code  (o_char_code),
        .o_last       (o_last),
        .o_status     (out_status)
    );

    assign full          = q_full;
    assign o_shift_held  = out_status.shift;
    assign o_ctrl_held   = out_status.ctrl;
    assign o_record_mode = out_status.mode;

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking bench for the keyboard scan decoder with record/playback macros.
// Depends on kbd_pkg and keyboard_scan_decoder_with_macro_top; predicts every result.
`default_nettype none

module tb;
    import kbd_pkg::*;

    localparam int REC_DEPTH      = 10;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 100;
    localparam int HOLD_AFTER     = 120;
    localparam int PAUSE_AT       = 200;
    localparam int STIM_ITEMS     = 340;

    localparam logic [7:0] SC_KEY_A = 8'd30;
    localparam logic [7:0] SC_KEY_H = 8'd35;
    localparam logic [7:0] SC_KEY_K = 8'd37;
    localparam logic [7:0] SC_KEY_Q = 8'd16;
    localparam logic [7:0] SC_KEY_W = 8'd17;
    localparam logic [7:0] SC_KEY_Z = 8'd44;
    localparam logic [7:0] SC_KEY_1 = 8'd2;

    typedef struct {
        logic [7:0] code;
        bit         drain;
    } t_keystroke;

    typedef struct {
        logic [1:0]        kind;
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              shift;
        logic              ctrl;
        logic [1:0]        mode;
    } t_decoded;

    // Set-1 make codes to ASCII; zero where no character is mapped
    logic [CHAR_W-1:0] set1_ascii [0:127] = '{
        0, 27, 49, 50, 51, 52, 53, 54, 55, 56, 57, 48, 45, 61, 8, 9,
        113, 119, 101, 114, 116, 121, 117, 105, 111, 112, 91, 93, 10, 0, 97, 115,
        100, 102, 103, 104, 106, 107, 108, 59, 39, 96, 0, 92, 122, 120, 99, 118,
        98, 110, 109, 44, 46, 47, 0, 42, 0, 32, 0, 0, 0, 0, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 55, 56, 57, 45, 52, 53, 54, 43, 49,
        50, 51, 48, 46, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
    };

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              push         = 1'b0;
    logic [7:0]        i_scan_code  = 8'd0;
    logic              pop          = 1'b0;
    logic              full;
    logic              empty;
    logic [1:0]        o_kind;
    logic [CHAR_W-1:0] o_char_code;
    logic              o_last;
    logic              o_shift_held;
    logic              o_ctrl_held;
    logic [1:0]        o_record_mode;

    // Predictor state
    logic              kb_shift;
    logic              kb_ctrl;
    t_mode             kb_mode;
    int                rec_count;
    logic [CHAR_W-1:0] rec_store [REC_DEPTH];

    t_keystroke keystroke_q [$];
    t_decoded   decoded_q [$];

    int err_count   = 0;
    int n_results   = 0;
    int burst_left  = 4;
    int gap_left    = 0;
    int hold_left   = 0;
    int rx_cycles   = 0;
    int idle_cycles = 0;
    bit long_hold_done = 1'b0;
    logic next_push;
    t_decoded want;

    keyboard_scan_decoder_with_macro_top #(
        .RECORD_DEPTH(REC_DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_scan_code   (i_scan_code),
        .empty         (empty),
        .pop           (pop),
        .o_kind        (o_kind),
        .o_char_code   (o_char_code),
        .o_last        (o_last),
        .o_shift_held  (o_shift_held),
        .o_ctrl_held   (o_ctrl_held),
        .o_record_mode (o_record_mode)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [CHAR_W-1:0] capital(input logic [CHAR_W-1:0] ch);
        if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
            return ch - CASE_DIFF;
        end
        return ch;
    endfunction

    function automatic void expect_decoded(input logic [1:0] kind, input logic [CHAR_W-1:0] ch,
                                           input logic last);
        t_decoded d;
        d.kind  = kind;
        d.ch    = ch;
        d.last  = last;
        d.shift = kb_shift;
        d.ctrl  = kb_ctrl;
        d.mode  = kb_mode;
        decoded_q.push_back(d);
    endfunction

    function automatic void clear_macro();
        for (int i = 0; i < REC_DEPTH; i++) begin
            rec_store[i] = CH_NUL;
        end
        rec_count = 0;
    endfunction

    // Advance the decoder state by one scan code and queue what it should emit
    function automatic void decode_scan(input logic [7:0] code);
        logic [CHAR_W-1:0] ch;
        case (code)
            SC_LSHIFT_MAKE:  kb_shift = 1'b1;
            SC_LSHIFT_BREAK: kb_shift = 1'b0;
            SC_LCTRL_MAKE:   kb_ctrl  = 1'b1;
            SC_LCTRL_BREAK:  kb_ctrl  = 1'b0;
            default: ;
        endcase
        if (code[7]) begin
            expect_decoded(KIND_NONE, CH_NUL, 1'b1);
        end else begin
            ch = set1_ascii[code[6:0]];
            if (kb_shift) begin
                ch = capital(ch);
            end
            if (!kb_ctrl) begin
                if (kb_mode == MODE_IDLE) begin
                    expect_decoded(KIND_CHAR, ch, 1'b1);
                end else begin
                    if (rec_count >= REC_DEPTH - 1) begin
                        kb_mode = MODE_IDLE;
                    end else begin
                        rec_store[rec_count] = (kb_mode == MODE_UPPER) ? capital(ch) : ch;
                        rec_count++;
                    end
                    expect_decoded(KIND_NONE, CH_NUL, 1'b1);
                end
            end else if (ch == CH_LOWER_H || ch == CH_UPPER_H) begin
                kb_mode = (ch == CH_LOWER_H) ? MODE_TYPED : MODE_UPPER;
                clear_macro();
                expect_decoded(KIND_NONE, CH_NUL, 1'b1);
            end else if (ch == CH_LOWER_K) begin
                rec_store[REC_DEPTH-1] = CH_NUL;
                kb_mode = MODE_IDLE;
                for (int i = 0; i < REC_DEPTH; i++) begin
                    expect_decoded(KIND_PLAY, rec_store[i], i == REC_DEPTH - 1);
                end
                clear_macro();
            end else begin
                expect_decoded(KIND_NONE, CH_NUL, 1'b1);
            end
        end
    endfunction

    // One item is marked to wait until every pending result has drained
    function automatic void add_code(input logic [7:0] code);
        t_keystroke k;
        k.code  = code;
        k.drain = (keystroke_q.size() == PAUSE_AT);
        keystroke_q.push_back(k);
    endfunction

    function automatic logic [7:0] rand_key();
        logic [7:0] code;
        do begin
            code = 8'($urandom_range(0, 127));
        end while (code == SC_LCTRL_MAKE);
        return code;
    endfunction

    // Record a random macro and usually play it back
    function automatic void add_macro_take();
        int n;
        add_code(SC_LCTRL_MAKE);
        if ($urandom_range(0, 1) == 1) begin
            add_code(SC_LSHIFT_MAKE);
        end
        add_code(SC_KEY_H);
        add_code(SC_LSHIFT_BREAK);
        add_code(SC_LCTRL_BREAK);
        n = $urandom_range(0, 12);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 5) == 0) begin
                add_code(8'($urandom_range(128, 255)));
            end else begin
                add_code(rand_key());
            end
        end
        add_code(SC_LSHIFT_BREAK);
        if ($urandom_range(0, 4) != 0) begin
            add_code(SC_LCTRL_MAKE);
            add_code(SC_KEY_K);
            add_code(SC_LCTRL_BREAK);
        end
    endfunction

    function automatic void add_typing();
        int n;
        n = $urandom_range(1, 8);
        if ($urandom_range(0, 2) == 0) begin
            add_code(SC_LSHIFT_MAKE);
        end
        for (int i = 0; i < n; i++) begin
            add_code(rand_key());
        end
        add_code(SC_LSHIFT_BREAK);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("ERROR result %0d at %0t: %s got %0d expected %0d",
                 n_results, $time, what, got, exp_val);
        err_count++;
    endtask

    // Sender: bursts with random gaps; hold the offer while full is high
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push        <= 1'b0;
            i_scan_code <= 8'd0;
        end else begin
            if (push && !full) begin
                decode_scan(i_scan_code);
            end
            next_push = 1'b0;
            if (push && full) begin
                next_push = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (keystroke_q.size() != 0 &&
                         (!keystroke_q[0].drain || decoded_q.size() == 0)) begin
                next_push = 1'b1;
                i_scan_code <= keystroke_q[0].code;
                void'(keystroke_q.pop_front());
                burst_left--;
                if (burst_left <= 0) begin
                    if ($urandom_range(0, 3) == 0) begin
                        gap_left   = 0;
                        burst_left = $urandom_range(30, 60);
                    end else begin
                        gap_left   = $urandom_range(1, 10);
                        burst_left = $urandom_range(1, 12);
                    end
                end
            end
            push <= next_push;
        end
    end

    // Receiver: check each transfer, stall on a phase pattern plus one long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            rx_cycles++;
            if (pop && !empty) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch("result with nothing pending, kind", int'(o_kind), -1);
                end else begin
                    want = decoded_q.pop_front();
                    if (o_kind !== want.kind)
                        report_mismatch("kind", int'(o_kind), int'(want.kind));
                    if (o_char_code !== want.ch)
                        report_mismatch("char_code", int'(o_char_code), int'(want.ch));
                    if (o_last !== want.last)
                        report_mismatch("last", int'(o_last), int'(want.last));
                    if (o_shift_held !== want.shift)
                        report_mismatch("shift_held", int'(o_shift_held), int'(want.shift));
                    if (o_ctrl_held !== want.ctrl)
                        report_mismatch("ctrl_held", int'(o_ctrl_held), int'(want.ctrl));
                    if (o_record_mode !== want.mode)
                        report_mismatch("record_mode", int'(o_record_mode), int'(want.mode));
                end
                n_results++;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (!long_hold_done && n_results >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD;
                pop <= 1'b0;
            end else begin
                case ((rx_cycles / 97) % 4)
                    0: pop <= 1'b1;
                    1: pop <= ($urandom_range(0, 1) == 1);
                    2: pop <= ($urandom_range(0, 3) == 0);
                    default: pop <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        kb_shift = 1'b0;
        kb_ctrl  = 1'b0;
        kb_mode  = MODE_IDLE;
        clear_macro();

        // Directed: code extremes, shift case, ctrl commands, playback
        add_code(8'd0);
        add_code(8'd127);
        add_code(8'd128);
        add_code(8'd255);
        add_code(SC_LSHIFT_MAKE);
        add_code(SC_KEY_A);
        add_code(SC_LSHIFT_BREAK);
        add_code(SC_KEY_A);
        add_code(SC_LCTRL_MAKE);
        add_code(SC_KEY_Q);
        add_code(SC_KEY_H);
        add_code(SC_LCTRL_BREAK);
        add_code(SC_KEY_W);
        add_code(SC_KEY_Z);
        add_code(SC_KEY_1);
        add_code(SC_LCTRL_MAKE);
        add_code(SC_KEY_K);
        add_code(SC_LSHIFT_MAKE);
        add_code(SC_KEY_H);
        add_code(SC_LSHIFT_BREAK);
        add_code(SC_LCTRL_BREAK);
        add_code(SC_KEY_A);
        add_code(SC_LCTRL_MAKE);
        add_code(SC_KEY_K);
        add_code(SC_LCTRL_BREAK);

        while (keystroke_q.size() < STIM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: add_macro_take();
                6, 7:             add_typing();
                default:          add_code(8'($urandom_range(0, 255)));
            endcase
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (keystroke_q.size() != 0 || push) begin
            @(posedge i_clk);
        end
        while (decoded_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4 * REC_DEPTH) @(posedge i_clk);

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
